/* rtl/fesg_pkg.sv */
`timescale 1ns / 1ps

package fesg_pkg;

   localparam int CX_W     = 11;
   localparam int RAD_W    = 5;
   localparam int SQ_W     = 10;
   localparam int PROD_W   = 20;
   localparam int ROW_W    = 12;
   localparam int COL_W    = 10;
   localparam int COLOUR_W = 8;
   localparam int DY_W     = 7;
   localparam int CLIP_W   = 13;
   localparam int STEP_W   = 5;

   localparam logic [STEP_W-1:0] DIV_LAST  = 5'd19;
   localparam logic [STEP_W-1:0] ROOT_LAST = 5'd9;
   localparam logic [PROD_W-1:0] ROOT_TOP  = 20'h40000;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam logic [COL_W-1:0] WIDTH_RESET  = 10'd320;
   localparam logic [COL_W-1:0] HEIGHT_RESET = 10'd240;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REM,
      ST_PROD,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic rem;
      logic prod;
      logic div_step;
      logic root_load;
      logic root_step;
      logic emit;
      logic next_row;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_zero;
      logic last_row;
      logic out_free;
   } status_type;

endpackage

/* rtl/fesg_if.sv */
`timescale 1ns / 1ps

interface fesg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fesg_pkg::CX_W-1:0]    mid_x;
   logic signed [fesg_pkg::CX_W-1:0]    mid_y;
   logic [fesg_pkg::RAD_W-1:0]          semi_x;
   logic [fesg_pkg::RAD_W-1:0]          semi_y;
   logic [fesg_pkg::COLOUR_W-1:0]       fill_colour;

   modport source (output valid, mid_x, mid_y, semi_x, semi_y, fill_colour,
                   input ready);
   modport sink (input valid, mid_x, mid_y, semi_x, semi_y, fill_colour,
                 output ready);
endinterface

interface fesg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fesg_pkg::ROW_W-1:0]   span_row;
   logic [fesg_pkg::COL_W-1:0]          span_left;
   logic [fesg_pkg::COL_W-1:0]          span_right;
   logic                                span_visible;
   logic [fesg_pkg::COLOUR_W-1:0]       span_colour;
   logic                                span_last;

   modport source (output valid, span_row, span_left, span_right, span_visible,
                   span_colour, span_last, input ready);
   modport sink (input valid, span_row, span_left, span_right, span_visible,
                 span_colour, span_last, output ready);
endinterface

/* rtl/filled_ellipse_span_generator_unit.sv */
`timescale 1ns / 1ps

// Filled ellipse span generator.
// req_ch takes one fill command per beat (centre, radii, colour); rsp_ch
// returns its spans in row order, top to bottom, the final one with
// span_last set. A command with a zero radius gives one single-pixel span.
// Each span is worked out by a squared-term update, one 10x10 multiply, a
// 20-step restoring divider, a root setup step, a 10-step bit-serial square
// root and the write into the output register, in that order, all sharing
// one datapath. A command of 2*ry+1 rows keeps the sequencer busy until
// the last of its spans has been written into the output register.
// A new command is accepted only once the last span of the previous one
// sits in the output register. When rsp_ch stalls, that register holds its
// span and the sequencer waits before writing the next one, so no work is
// lost. Reset returns the sequencer to idle, empties the output register
// and sets the surface to 320 x 240. The surface registers sit on the APB
// port at 0x0 (width) and 0x4 (height); write them only while idle.
module filled_ellipse_span_generator_unit #(
   parameter int MAX_RADIUS  = 31,
   parameter int COORD_LIMIT = 1023
) (
   input  logic         clock,
   input  logic         reset,
   fesg_req_if.sink     req_ch,
   fesg_rsp_if.source   rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   fesg_pkg::cmd_type             cmd;
   fesg_pkg::status_type          status;
   logic [fesg_pkg::COL_W-1:0]    surface_width;
   logic [fesg_pkg::COL_W-1:0]    surface_height;

   fesg_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .surface_width  (surface_width),
      .surface_height (surface_height)
   );

   fesg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   fesg_datapath #(
      .MAX_RADIUS  (MAX_RADIUS),
      .COORD_LIMIT (COORD_LIMIT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .cmd            (cmd),
      .status         (status),
      .surface_width  (surface_width),
      .surface_height (surface_height)
   );

endmodule

/* rtl/fesg_csr.sv */
`timescale 1ns / 1ps

module fesg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [fesg_pkg::COL_W-1:0]  surface_width,
   output logic [fesg_pkg::COL_W-1:0]  surface_height
);

   logic [fesg_pkg::COL_W-1:0] width_ff, width_in;
   logic [fesg_pkg::COL_W-1:0] height_ff, height_in;
   logic                       wr;

   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         case (paddr[2])
            fesg_pkg::CSR_IDX_WIDTH:  width_in  = pwdata[fesg_pkg::COL_W-1:0];
            fesg_pkg::CSR_IDX_HEIGHT: height_in = pwdata[fesg_pkg::COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fesg_pkg::WIDTH_RESET;
         height_ff <= fesg_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (paddr[2])
         fesg_pkg::CSR_IDX_WIDTH:  prdata = {22'd0, width_ff};
         fesg_pkg::CSR_IDX_HEIGHT: prdata = {22'd0, height_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   assign surface_width  = width_ff;
   assign surface_height = height_ff;

endmodule

/* rtl/fesg_ctrl.sv */
`timescale 1ns / 1ps

module fesg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  fesg_pkg::status_type   status,
   output fesg_pkg::cmd_type      cmd
);

   fesg_pkg::state_type             state_ff, state_in;
   logic [fesg_pkg::STEP_W-1:0]     cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fesg_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               state_in = status.req_zero ? fesg_pkg::ST_EMIT : fesg_pkg::ST_REM;
            end
         end
         fesg_pkg::ST_REM:  state_in = fesg_pkg::ST_PROD;
         fesg_pkg::ST_PROD: state_in = fesg_pkg::ST_DIV;
         fesg_pkg::ST_DIV: begin
            if (cnt_ff == fesg_pkg::DIV_LAST) state_in = fesg_pkg::ST_ROOT_LOAD;
         end
         fesg_pkg::ST_ROOT_LOAD: state_in = fesg_pkg::ST_ROOT;
         fesg_pkg::ST_ROOT: begin
            if (cnt_ff == fesg_pkg::ROOT_LAST) state_in = fesg_pkg::ST_EMIT;
         end
         fesg_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.last_row ? fesg_pkg::ST_IDLE : fesg_pkg::ST_REM;
            end
         end
         default: state_in = fesg_pkg::ST_IDLE;
      endcase
   end

   // step counter restarts whenever the current loop state is left
   always_comb begin
      cnt_in = '0;
      if ((state_ff == fesg_pkg::ST_DIV || state_ff == fesg_pkg::ST_ROOT) &&
          state_in == state_ff) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fesg_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.take      = (state_ff == fesg_pkg::ST_IDLE);
      cmd.rem       = (state_ff == fesg_pkg::ST_REM);
      cmd.prod      = (state_ff == fesg_pkg::ST_PROD);
      cmd.div_step  = (state_ff == fesg_pkg::ST_DIV);
      cmd.root_load = (state_ff == fesg_pkg::ST_ROOT_LOAD);
      cmd.root_step = (state_ff == fesg_pkg::ST_ROOT);
      cmd.emit      = (state_ff == fesg_pkg::ST_EMIT) && status.out_free;
      cmd.next_row  = (state_ff == fesg_pkg::ST_EMIT) && status.out_free &&
                      !status.last_row;
   end

endmodule

/* rtl/fesg_datapath.sv */
`timescale 1ns / 1ps

module fesg_datapath #(
   parameter int MAX_RADIUS  = 31,
   parameter int COORD_LIMIT = 1023
) (
   input  logic                        clock,
   input  logic                        reset,
   fesg_req_if.sink                    req_ch,
   fesg_rsp_if.source                  rsp_ch,
   input  fesg_pkg::cmd_type           cmd,
   output fesg_pkg::status_type        status,
   input  logic [fesg_pkg::COL_W-1:0]  surface_width,
   input  logic [fesg_pkg::COL_W-1:0]  surface_height
);

   localparam int CW = fesg_pkg::CLIP_W;

   logic signed [fesg_pkg::CX_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [fesg_pkg::COLOUR_W-1:0]     colour_ff, colour_in;
   logic [fesg_pkg::RAD_W-1:0]        ry_ff, ry_in;
   logic [fesg_pkg::SQ_W-1:0]         rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic signed [fesg_pkg::DY_W-1:0]  dy_ff, dy_in;
   logic [fesg_pkg::SQ_W-1:0]         rem_ff, rem_in;
   logic [fesg_pkg::SQ_W-1:0]         part_ff, part_in;
   logic [fesg_pkg::PROD_W-1:0]       quot_ff, quot_in;
   logic [fesg_pkg::PROD_W-1:0]       val_ff, val_in, res_ff, res_in, bit_ff, bit_in;

   logic                              vld_ff, vld_in;
   logic signed [fesg_pkg::ROW_W-1:0] row_ff, row_in;
   logic [fesg_pkg::COL_W-1:0]        left_ff, left_in, right_ff, right_in;
   logic                              vis_ff, vis_in, last_ff, last_in;
   logic [fesg_pkg::COLOUR_W-1:0]     ocol_ff, ocol_in;

   logic                              load;
   logic [fesg_pkg::RAD_W-1:0]        rx_sat, ry_sat;
   logic signed [fesg_pkg::DY_W-1:0]  ady;
   logic [fesg_pkg::SQ_W-1:0]         ady_sq;
   logic [fesg_pkg::SQ_W:0]           trial, diff;
   logic                              div_ge;
   logic [fesg_pkg::PROD_W:0]         root_sum;
   logic                              root_ge;
   logic                              last_row;

   logic signed [fesg_pkg::ROW_W-1:0] row;
   logic signed [CW-1:0]              row_c, cx_c, half_c, x0, x1, lft, rgt;
   logic signed [CW-1:0]              w_raw, h_raw, w_c, h_c, lim_c;
   logic                              vis;

   assign load = cmd.take && req_ch.valid;
   assign req_ch.ready = cmd.take;

   assign rx_sat = (req_ch.semi_x > fesg_pkg::RAD_W'(MAX_RADIUS)) ?
                   fesg_pkg::RAD_W'(MAX_RADIUS) : req_ch.semi_x;
   assign ry_sat = (req_ch.semi_y > fesg_pkg::RAD_W'(MAX_RADIUS)) ?
                   fesg_pkg::RAD_W'(MAX_RADIUS) : req_ch.semi_y;

   assign ady    = (dy_ff < 0) ? -dy_ff : dy_ff;
   assign ady_sq = {5'd0, ady[fesg_pkg::RAD_W-1:0]} * {5'd0, ady[fesg_pkg::RAD_W-1:0]};

   // restoring division, one quotient bit a step
   assign trial  = {part_ff, quot_ff[fesg_pkg::PROD_W-1]};
   assign div_ge = trial >= {1'b0, ry2_ff};
   assign diff   = trial - {1'b0, ry2_ff};

   assign root_sum = {1'b0, res_ff} + {1'b0, bit_ff};
   assign root_ge  = {1'b0, val_ff} >= root_sum;

   assign last_row = (dy_ff == $signed({2'b00, ry_ff}));

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      colour_in = colour_ff;
      ry_in     = ry_ff;
      rx2_in    = rx2_ff;
      ry2_in    = ry2_ff;
      dy_in     = dy_ff;
      rem_in    = rem_ff;
      part_in   = part_ff;
      quot_in   = quot_ff;
      val_in    = val_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      if (load) begin
         cx_in     = req_ch.mid_x;
         cy_in     = req_ch.mid_y;
         colour_in = req_ch.fill_colour;
         rx2_in    = {5'd0, rx_sat} * {5'd0, rx_sat};
         ry2_in    = {5'd0, ry_sat} * {5'd0, ry_sat};
         // zero radius collapses to one pixel: ry forced to zero, half stays zero
         if (rx_sat == '0 || ry_sat == '0) begin
            ry_in = '0;
            dy_in = '0;
         end else begin
            ry_in = ry_sat;
            dy_in = -$signed({2'b00, ry_sat});
         end
         res_in = '0;
      end
      if (cmd.rem) begin
         rem_in = ry2_ff - ady_sq;
      end
      if (cmd.prod) begin
         quot_in = {10'd0, rem_ff} * {10'd0, rx2_ff};
         part_in = '0;
      end
      if (cmd.div_step) begin
         part_in = div_ge ? diff[fesg_pkg::SQ_W-1:0] : trial[fesg_pkg::SQ_W-1:0];
         quot_in = {quot_ff[fesg_pkg::PROD_W-2:0], div_ge};
      end
      if (cmd.root_load) begin
         val_in = quot_ff;
         res_in = '0;
         bit_in = fesg_pkg::ROOT_TOP;
      end
      if (cmd.root_step) begin
         if (root_ge) begin
            val_in = val_ff - root_sum[fesg_pkg::PROD_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.next_row) begin
         dy_in = dy_ff + fesg_pkg::DY_W'(1);
      end
   end

   // clipping against the surface
   assign row    = $signed({cy_ff[fesg_pkg::CX_W-1], cy_ff}) +
                   $signed({{5{dy_ff[fesg_pkg::DY_W-1]}}, dy_ff});
   assign row_c  = $signed({row[fesg_pkg::ROW_W-1], row});
   assign cx_c   = $signed({{2{cx_ff[fesg_pkg::CX_W-1]}}, cx_ff});
   assign half_c = $signed({3'd0, res_ff[fesg_pkg::SQ_W-1:0]});
   assign x0     = cx_c - half_c;
   assign x1     = cx_c + half_c;
   assign lim_c  = CW'(COORD_LIMIT);
   assign w_raw  = $signed({3'd0, surface_width});
   assign h_raw  = $signed({3'd0, surface_height});
   assign w_c    = (w_raw < lim_c) ? w_raw : lim_c;
   assign h_c    = (h_raw < lim_c) ? h_raw : lim_c;
   assign lft    = (x0 < 0) ? '0 : x0;
   assign rgt    = (x1 > w_c - CW'(1)) ? w_c - CW'(1) : x1;
   assign vis    = (row_c >= 0) && (row_c < h_c) && (lft <= rgt);

   always_comb begin
      vld_in   = vld_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      vis_in   = vis_ff;
      last_in  = last_ff;
      ocol_in  = ocol_ff;
      if (rsp_ch.ready) begin
         vld_in = 1'b0;
      end
      if (cmd.emit) begin
         vld_in   = 1'b1;
         row_in   = row;
         left_in  = vis ? lft[fesg_pkg::COL_W-1:0] : '0;
         right_in = vis ? rgt[fesg_pkg::COL_W-1:0] : '0;
         vis_in   = vis;
         last_in  = last_row;
         ocol_in  = colour_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      colour_ff <= colour_in;
      ry_ff     <= ry_in;
      rx2_ff    <= rx2_in;
      ry2_ff    <= ry2_in;
      dy_ff     <= dy_in;
      rem_ff    <= rem_in;
      part_ff   <= part_in;
      quot_ff   <= quot_in;
      val_ff    <= val_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      row_ff    <= row_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      vis_ff    <= vis_in;
      last_ff   <= last_in;
      ocol_ff   <= ocol_in;
   end

   assign rsp_ch.valid        = vld_ff;
   assign rsp_ch.span_row     = row_ff;
   assign rsp_ch.span_left    = left_ff;
   assign rsp_ch.span_right   = right_ff;
   assign rsp_ch.span_visible = vis_ff;
   assign rsp_ch.span_colour  = ocol_ff;
   assign rsp_ch.span_last    = last_ff;

   always_comb begin
      status           = '0;
      status.req_valid = req_ch.valid;
      status.req_zero  = (rx_sat == '0) || (ry_sat == '0);
      status.last_row  = last_row;
      status.out_free  = !vld_ff || rsp_ch.ready;
   end

endmodule
